// ----- rtl/allocation_overlap_checker_macros.svh -----
// Assertion macros used by the allocation overlap checker controller.
// Each macro expands to a concurrent assertion in simulation and to nothing
// when SYNTHESIS is defined. No other file dependencies.
`ifndef ALLOCATION_OVERLAP_CHECKER_MACROS_SVH
`define ALLOCATION_OVERLAP_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AOC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aoc assertion failed: same-cycle implication");

// next-cycle implication
`define AOC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aoc assertion failed: next-cycle implication");

`else

`define AOC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define AOC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/aoc_pkg.sv -----
// Package for the allocation overlap checker: field widths, opcodes,
// status codes and the controller/datapath command and status structs.
// No dependencies.
package aoc_pkg;

   localparam int OPCODE_W      = 2;
   localparam int RANGE_START_W = 48;
   localparam int RANGE_SIZE_W  = 24;
   localparam int FREE_INDEX_W  = 4;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_IDX_W   = 4;

   localparam int AOC_MAX_ENTRIES = 16;
   localparam int AOC_ADDR_BITS   = 48;

   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADIDX  = 2'd3;

   typedef struct packed {
      logic load;         // capture the incoming item's fields
      logic clear_count;  // empty the table
      logic scan_start;   // rewind scan pointer, drop hit
      logic scan_en;      // walk the table, one read per cycle
      logic read_k;       // read the entry named by a free
      logic latch_match;  // keep that entry's address
      logic mode_free;    // scan marks matches instead of checking overlap
      logic append;       // store the new range
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic k_bad;
      logic scan_done;
      logic hit_found;
   } stat_type;

endpackage

// ----- rtl/allocation_overlap_checker.sv -----
// Allocation overlap checker. Clear, an unused opcode or a refused item go
// straight to S_DONE; allocate scans the table if not empty, then appends;
// free reads the named entry, keeps its address and scans (one RAM read per
// cycle). One item at a time; the next item can be taken in the cycle after
// the result is loaded into the output register, whether or not it is stalled.
// Synchronous active-high reset empties the table; entries need no clearing.
module allocation_overlap_checker
   import aoc_pkg::*;
#(
   parameter int MAX_ENTRIES = AOC_MAX_ENTRIES,
   parameter int ADDR_BITS   = AOC_ADDR_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // range_start [47:0], range_size [71:48], free_index [75:72], zero fill
   input  logic [79:0]         req_tdata,
   // opcode [1:0]
   input  logic [OPCODE_W-1:0] req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // overlap_entry [3:0], new_entry [7:4]
   output logic [7:0]          rsp_tdata,
   // status [1:0]
   output logic [STATUS_W-1:0] rsp_tuser
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);

   cmd_type                cmd;
   stat_type               st;
   logic [IDX_W-1:0]       hit_idx;
   logic [IDX_W-1:0]       new_idx;
   logic [ENTRY_IDX_W-1:0] ovl_entry;
   logic [ENTRY_IDX_W-1:0] new_entry;

   aoc_controller #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_opcode        (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_status        (rsp_tuser),
      .rsp_overlap_entry (ovl_entry),
      .rsp_new_entry     (new_entry),
      .cmd               (cmd),
      .st                (st),
      .hit_idx           (hit_idx),
      .new_idx           (new_idx)
   );

   aoc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_range_start (req_tdata[47:0]),
      .req_range_size  (req_tdata[71:48]),
      .req_free_index  (req_tdata[75:72]),
      .st              (st),
      .hit_idx         (hit_idx),
      .new_idx         (new_idx)
   );

   assign rsp_tdata = {new_entry, ovl_entry};

endmodule

// ----- rtl/aoc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
module aoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/aoc_datapath.sv -----
// Datapath of the allocation overlap checker: entry table RAM, fill count,
// scan pointer and the range containment / address match check.
// Depends on aoc_pkg and aoc_ram.
module aoc_datapath
   import aoc_pkg::*;
#(
   parameter int MAX_ENTRIES = AOC_MAX_ENTRIES,
   parameter int ADDR_BITS   = AOC_ADDR_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   input  logic [RANGE_START_W-1:0]       req_range_start,
   input  logic [RANGE_SIZE_W-1:0]        req_range_size,
   input  logic [FREE_INDEX_W-1:0]        req_free_index,
   output stat_type                       st,
   output logic [$clog2(MAX_ENTRIES)-1:0] hit_idx,
   output logic [$clog2(MAX_ENTRIES)-1:0] new_idx
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > FREE_INDEX_W) ? CNT_W : FREE_INDEX_W;
   localparam int IN_W  = (ADDR_BITS > RANGE_START_W) ? ADDR_BITS : RANGE_START_W;
   localparam int CW    = (ADDR_BITS > RANGE_SIZE_W) ? ADDR_BITS : RANGE_SIZE_W;
   localparam int EW    = ADDR_BITS + RANGE_SIZE_W + 1;

   logic [ADDR_BITS-1:0]    first_ff;
   logic [ADDR_BITS-1:0]    last_ff;
   logic [RANGE_SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]        k_ff;
   logic [ADDR_BITS-1:0]    match_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        rd_ptr_ff;
   logic                    chk_valid_ff;
   logic [IDX_W-1:0]        chk_ptr_ff;
   logic                    hit_found_ff;
   logic [IDX_W-1:0]        hit_idx_ff;

   logic [IN_W-1:0]         rs_ext;
   logic [ADDR_BITS-1:0]    first_in;
   logic [CW-1:0]           last_sum;
   logic [CMP_W-1:0]        k_ext;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [EW-1:0]           wr_data;
   logic [IDX_W-1:0]        rd_addr;
   logic [EW-1:0]           rd_data;

   logic [ADDR_BITS-1:0]    e_addr;
   logic [RANGE_SIZE_W-1:0] e_len;
   logic                    e_rel;
   logic [ADDR_BITS:0]      diff_first;
   logic [ADDR_BITS:0]      diff_last;
   logic                    in_first;
   logic                    in_last;
   logic                    hit_now;
   logic                    match_now;
   logic                    more;
   logic                    issue;

   assign rs_ext   = IN_W'(req_range_start);
   assign first_in = rs_ext[ADDR_BITS-1:0];
   // last byte wraps in the address space
   assign last_sum = CW'(first_in) + CW'(req_range_size) - CW'(1);
   assign k_ext    = CMP_W'(req_free_index);

   assign e_addr = rd_data[ADDR_BITS-1:0];
   assign e_len  = rd_data[ADDR_BITS +: RANGE_SIZE_W];
   assign e_rel  = rd_data[EW-1];

   // containment is exact: no wrap past the top of the address space
   assign diff_first = {1'b0, first_ff} - {1'b0, e_addr};
   assign diff_last  = {1'b0, last_ff} - {1'b0, e_addr};
   assign in_first   = !diff_first[ADDR_BITS] &&
                       (CW'(diff_first[ADDR_BITS-1:0]) < CW'(e_len));
   assign in_last    = !diff_last[ADDR_BITS] &&
                       (CW'(diff_last[ADDR_BITS-1:0]) < CW'(e_len));

   assign hit_now   = chk_valid_ff && !cmd.mode_free && !e_rel && (in_first || in_last);
   assign match_now = chk_valid_ff && cmd.mode_free && (e_addr == match_ff);

   assign more  = rd_ptr_ff < count_ff;
   assign issue = cmd.scan_en && more;

   assign rd_addr = cmd.read_k ? k_ff : rd_ptr_ff[IDX_W-1:0];
   assign wr_en   = match_now || cmd.append;
   assign wr_addr = cmd.append ? count_ff[IDX_W-1:0] : chk_ptr_ff;
   assign wr_data = cmd.append ? {1'b0, size_ff, first_ff} : {1'b1, e_len, e_addr};

   aoc_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         first_ff <= first_in;
         last_ff  <= last_sum[ADDR_BITS-1:0];
         size_ff  <= req_range_size;
         k_ff     <= k_ext[IDX_W-1:0];
      end
      if (cmd.latch_match) begin
         match_ff <= e_addr;
      end
      if (issue) begin
         chk_ptr_ff <= rd_ptr_ff[IDX_W-1:0];
      end
      if (hit_now && !hit_found_ff) begin
         hit_idx_ff <= chk_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         chk_valid_ff <= 1'b0;
         hit_found_ff <= 1'b0;
      end else begin
         if (cmd.clear_count) begin
            count_ff <= '0;
         end else if (cmd.append) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.scan_start) begin
            rd_ptr_ff    <= '0;
            chk_valid_ff <= 1'b0;
            hit_found_ff <= 1'b0;
         end else begin
            if (issue) begin
               rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
            end
            chk_valid_ff <= issue;
            if (hit_now) begin
               hit_found_ff <= 1'b1;
            end
         end
      end
   end

   assign st.full      = count_ff == CNT_W'(MAX_ENTRIES);
   assign st.empty     = count_ff == '0;
   assign st.k_bad     = k_ext >= CMP_W'(count_ff);
   assign st.scan_done = !more && !chk_valid_ff;
   assign st.hit_found = hit_found_ff;
   assign hit_idx      = hit_idx_ff;
   assign new_idx      = count_ff[IDX_W-1:0];

endmodule

// ----- rtl/aoc_controller.sv -----
// Controller of the allocation overlap checker: sequencing state machine
// and the result output register. Depends on aoc_pkg and the assertion macros.
`include "allocation_overlap_checker_macros.svh"

module aoc_controller
   import aoc_pkg::*;
#(
   parameter int MAX_ENTRIES = AOC_MAX_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [OPCODE_W-1:0]            req_opcode,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [ENTRY_IDX_W-1:0]         rsp_overlap_entry,
   output logic [ENTRY_IDX_W-1:0]         rsp_new_entry,
   output cmd_type                        cmd,
   input  stat_type                       st,
   input  logic [$clog2(MAX_ENTRIES)-1:0] hit_idx,
   input  logic [$clog2(MAX_ENTRIES)-1:0] new_idx
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int XW    = (IDX_W > ENTRY_IDX_W) ? IDX_W : ENTRY_IDX_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FREE_RD,
      S_FREE_ADDR,
      S_SCAN,
      S_APPEND,
      S_DONE
   } state_type;

   state_type               state_ff;
   logic                    mode_free_ff;
   logic [STATUS_W-1:0]     res_status_ff;
   logic [ENTRY_IDX_W-1:0]  res_ovl_ff;
   logic [ENTRY_IDX_W-1:0]  res_new_ff;
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [ENTRY_IDX_W-1:0]  rsp_ovl_ff;
   logic [ENTRY_IDX_W-1:0]  rsp_new_ff;

   logic                    accept;
   logic                    rsp_free;
   logic [XW-1:0]           hit_x;
   logic [XW-1:0]           new_x;

   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign hit_x      = XW'(hit_idx);
   assign new_x      = XW'(new_idx);

   always_comb begin
      cmd             = '0;
      cmd.mode_free   = mode_free_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load        = accept;
            cmd.scan_start  = accept;
            cmd.clear_count = accept && (req_opcode == OP_CLEAR);
         end
         S_FREE_RD:   cmd.read_k      = 1'b1;
         S_FREE_ADDR: cmd.latch_match = 1'b1;
         S_SCAN:      cmd.scan_en     = 1'b1;
         S_APPEND:    cmd.append      = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_free_ff  <= 1'b0;
         res_status_ff <= ST_OK;
         res_ovl_ff    <= '0;
         res_new_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_ovl_ff    <= '0;
         rsp_new_ff    <= '0;
      end else begin
         // a result loaded in S_DONE keeps the valid high
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  res_ovl_ff    <= '0;
                  res_new_ff    <= '0;
                  case (req_opcode)
                     OP_ALLOC: begin
                        mode_free_ff <= 1'b0;
                        if (st.full) begin
                           res_status_ff <= ST_FULL;
                           state_ff      <= S_DONE;
                        end else if (st.empty) begin
                           res_status_ff <= ST_OK;
                           state_ff      <= S_APPEND;
                        end else begin
                           res_status_ff <= ST_OK;
                           state_ff      <= S_SCAN;
                        end
                     end
                     OP_FREE: begin
                        mode_free_ff <= 1'b1;
                        if (st.k_bad) begin
                           res_status_ff <= ST_BADIDX;
                           state_ff      <= S_DONE;
                        end else begin
                           res_status_ff <= ST_OK;
                           state_ff      <= S_FREE_RD;
                        end
                     end
                     default: begin  // clear, or an unused code
                        res_status_ff <= ST_OK;
                        state_ff      <= S_DONE;
                     end
                  endcase
               end
            end
            S_FREE_RD:   state_ff <= S_FREE_ADDR;
            S_FREE_ADDR: state_ff <= S_SCAN;
            S_SCAN: begin
               if (st.scan_done) begin
                  state_ff <= mode_free_ff ? S_DONE : S_APPEND;
               end
            end
            S_APPEND: begin
               res_status_ff <= st.hit_found ? ST_OVERLAP : ST_OK;
               res_ovl_ff    <= st.hit_found ? hit_x[ENTRY_IDX_W-1:0] : '0;
               res_new_ff    <= new_x[ENTRY_IDX_W-1:0];
               state_ff      <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_ovl_ff    <= res_ovl_ff;
                  rsp_new_ff    <= res_new_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_overlap_entry = rsp_ovl_ff;
   assign rsp_new_entry     = rsp_new_ff;

   `AOC_ASSERT_IMP(a_no_append_when_full, clock, reset, state_ff == S_APPEND, !st.full)
   `AOC_ASSERT_NXT(a_bad_free_reported, clock, reset,
                   accept && req_opcode == OP_FREE && st.k_bad,
                   state_ff == S_DONE && res_status_ff == ST_BADIDX)
   `AOC_ASSERT_NXT(a_alloc_scan_appends, clock, reset,
                   state_ff == S_SCAN && st.scan_done && !mode_free_ff, state_ff == S_APPEND)
   `AOC_ASSERT_IMP(a_overlap_idx_only_on_hit, clock, reset,
                   rsp_valid_ff && rsp_status_ff != ST_OVERLAP, rsp_ovl_ff == '0)

endmodule
